### hdl/ppmfd_pkg.sv
package ppmfd_pkg;

   // Frame geometry.
   localparam int MAX_CHANNELS = 16;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int IDX_W = $clog2(MAX_CHANNELS);
   // Width that holds both a read index and the channel limit.
   localparam int RD_W = (CNT_W > 4) ? CNT_W : 4;
   localparam int MIN_RECOVER_CHANNELS = 4;

   // Field widths.
   localparam int CMD_W = 2;
   localparam int INTERVAL_W = 16;
   localparam int CHIDX_W = 4;
   localparam int CHAN_W = 12;
   localparam int OUT_CNT_W = 5;
   localparam int SINCE_W = 17;
   localparam int WARMUP_W = 5;

   localparam logic [CHAN_W-1:0] CHAN_MAX = '1;
   localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);
   localparam logic [CNT_W-1:0] CNT_RECOVER = CNT_W'(MIN_RECOVER_CHANNELS);
   localparam logic [RD_W-1:0] RD_MAX = RD_W'(MAX_CHANNELS);

   // Configuration port.
   localparam int NUM_REGS = 6;
   localparam int PADDR_W = $clog2(NUM_REGS * 4);
   localparam int PDATA_W = 32;
   localparam int REG_IDX_W = PADDR_W - 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ENABLED = 0,
      REG_SYNC_THRESHOLD = 1,
      REG_MIN_PULSE = 2,
      REG_MAX_PULSE = 3,
      REG_LOSS_TIMEOUT = 4,
      REG_WARMUP_POLLS = 5
   } reg_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_EDGE = 2'd0,
      CMD_TICK = 2'd1,
      CMD_POLL = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      logic enabled;
      logic [INTERVAL_W-1:0] sync_threshold_us;
      logic [INTERVAL_W-1:0] min_pulse_us;
      logic [INTERVAL_W-1:0] max_pulse_us;
      logic [SINCE_W-1:0] loss_timeout_us;
      logic [WARMUP_W-1:0] warmup_polls;
   } cfg_type;

   typedef struct packed {
      cmd_type command;
      logic [INTERVAL_W-1:0] interval_us;
      logic [CHIDX_W-1:0] channel_index;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_value;
      logic [OUT_CNT_W-1:0] channel_count;
      logic signal_lost;
      logic frame_done;
   } rsp_type;

   localparam logic [SINCE_W-1:0] RST_LOSS_TIMEOUT = SINCE_W'(60000);
   localparam logic [INTERVAL_W-1:0] RST_SYNC_THRESHOLD = INTERVAL_W'(2990);
   localparam logic [INTERVAL_W-1:0] RST_MIN_PULSE = INTERVAL_W'(900);
   localparam logic [INTERVAL_W-1:0] RST_MAX_PULSE = INTERVAL_W'(2100);
   localparam logic [WARMUP_W-1:0] RST_WARMUP_POLLS = WARMUP_W'(20);

endpackage

### hdl/ppmfd_req_if.sv
interface ppmfd_req_if;
   logic valid;
   logic ready;
   logic [ppmfd_pkg::CMD_W-1:0] command;
   logic [ppmfd_pkg::INTERVAL_W-1:0] interval_us;
   logic [ppmfd_pkg::CHIDX_W-1:0] channel_index;

   modport source (output valid, command, interval_us, channel_index, input ready);
   modport sink (input valid, command, interval_us, channel_index, output ready);
endinterface

### hdl/ppmfd_rsp_if.sv
interface ppmfd_rsp_if;
   logic valid;
   logic ready;
   logic [ppmfd_pkg::CHAN_W-1:0] channel_value;
   logic [ppmfd_pkg::OUT_CNT_W-1:0] channel_count;
   logic signal_lost;
   logic frame_done;

   modport source (output valid, channel_value, channel_count, signal_lost, frame_done,
      input ready);
   modport sink (input valid, channel_value, channel_count, signal_lost, frame_done,
      output ready);
endinterface

### hdl/ppmfd_csr.sv
module ppmfd_csr (
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [ppmfd_pkg::PADDR_W-1:0] csr_paddr,
   input logic [ppmfd_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [ppmfd_pkg::PDATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output ppmfd_pkg::cfg_type cfg
);

   ppmfd_pkg::cfg_type cfg_ff;
   ppmfd_pkg::cfg_type cfg_in;
   ppmfd_pkg::reg_index_type reg_index;
   logic write_en;

   assign csr_pready = 1'b1;
   assign reg_index = ppmfd_pkg::reg_index_type'(csr_paddr[ppmfd_pkg::PADDR_W-1:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   // Register write decode; addresses beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            ppmfd_pkg::REG_ENABLED: cfg_in.enabled = csr_pwdata[0];
            ppmfd_pkg::REG_SYNC_THRESHOLD:
               cfg_in.sync_threshold_us = csr_pwdata[ppmfd_pkg::INTERVAL_W-1:0];
            ppmfd_pkg::REG_MIN_PULSE:
               cfg_in.min_pulse_us = csr_pwdata[ppmfd_pkg::INTERVAL_W-1:0];
            ppmfd_pkg::REG_MAX_PULSE:
               cfg_in.max_pulse_us = csr_pwdata[ppmfd_pkg::INTERVAL_W-1:0];
            ppmfd_pkg::REG_LOSS_TIMEOUT:
               cfg_in.loss_timeout_us = csr_pwdata[ppmfd_pkg::SINCE_W-1:0];
            ppmfd_pkg::REG_WARMUP_POLLS:
               cfg_in.warmup_polls = csr_pwdata[ppmfd_pkg::WARMUP_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_index)
         ppmfd_pkg::REG_ENABLED: csr_prdata = ppmfd_pkg::PDATA_W'(cfg_ff.enabled);
         ppmfd_pkg::REG_SYNC_THRESHOLD:
            csr_prdata = ppmfd_pkg::PDATA_W'(cfg_ff.sync_threshold_us);
         ppmfd_pkg::REG_MIN_PULSE: csr_prdata = ppmfd_pkg::PDATA_W'(cfg_ff.min_pulse_us);
         ppmfd_pkg::REG_MAX_PULSE: csr_prdata = ppmfd_pkg::PDATA_W'(cfg_ff.max_pulse_us);
         ppmfd_pkg::REG_LOSS_TIMEOUT:
            csr_prdata = ppmfd_pkg::PDATA_W'(cfg_ff.loss_timeout_us);
         ppmfd_pkg::REG_WARMUP_POLLS:
            csr_prdata = ppmfd_pkg::PDATA_W'(cfg_ff.warmup_polls);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled <= 1'b0;
         cfg_ff.sync_threshold_us <= ppmfd_pkg::RST_SYNC_THRESHOLD;
         cfg_ff.min_pulse_us <= ppmfd_pkg::RST_MIN_PULSE;
         cfg_ff.max_pulse_us <= ppmfd_pkg::RST_MAX_PULSE;
         cfg_ff.loss_timeout_us <= ppmfd_pkg::RST_LOSS_TIMEOUT;
         cfg_ff.warmup_polls <= ppmfd_pkg::RST_WARMUP_POLLS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/ppmfd_core.sv
module ppmfd_core (
   input logic clock,
   input logic reset,
   input logic fire,
   input ppmfd_pkg::req_type req,
   input ppmfd_pkg::cfg_type cfg,
   output ppmfd_pkg::rsp_type rsp
);

   logic frame_started_ff, frame_started_in;
   ppmfd_pkg::count_type capture_count_ff, capture_count_in;
   ppmfd_pkg::count_type published_count_ff, published_count_in;
   logic [ppmfd_pkg::SINCE_W-1:0] since_sync_ff, since_sync_in;
   logic [ppmfd_pkg::WARMUP_W-1:0] warmup_count_ff, warmup_count_in;
   logic loss_latched_ff, loss_latched_in;
   ppmfd_pkg::chan_type capture_store_ff [ppmfd_pkg::MAX_CHANNELS];
   ppmfd_pkg::chan_type published_store_ff [ppmfd_pkg::MAX_CHANNELS];

   logic do_publish;
   logic do_store;
   ppmfd_pkg::chan_type store_value;
   logic [ppmfd_pkg::IDX_W-1:0] store_addr;
   ppmfd_pkg::count_type readable_count;
   logic [ppmfd_pkg::RD_W-1:0] rd_ext;
   logic [ppmfd_pkg::IDX_W-1:0] rd_addr;
   logic rd_hit;

   // Saturated channel value and its slot in the capture store.
   assign store_value = (req.interval_us > ppmfd_pkg::INTERVAL_W'(ppmfd_pkg::CHAN_MAX)) ?
      ppmfd_pkg::CHAN_MAX : req.interval_us[ppmfd_pkg::CHAN_W-1:0];
   assign store_addr = capture_count_ff[ppmfd_pkg::IDX_W-1:0];

   // Next state for the item in the input register.
   always_comb begin
      frame_started_in = frame_started_ff;
      capture_count_in = capture_count_ff;
      published_count_in = published_count_ff;
      since_sync_in = since_sync_ff;
      warmup_count_in = warmup_count_ff;
      loss_latched_in = loss_latched_ff;
      do_publish = 1'b0;
      do_store = 1'b0;
      if (fire) begin
         case (req.command)
            ppmfd_pkg::CMD_EDGE: begin
               if (req.interval_us > cfg.sync_threshold_us) begin
                  do_publish = 1'b1;
                  published_count_in = capture_count_ff;
                  capture_count_in = '0;
                  frame_started_in = 1'b1;
                  since_sync_in = '0;
               end else if (req.interval_us > cfg.min_pulse_us &&
                            req.interval_us < cfg.max_pulse_us &&
                            frame_started_ff &&
                            capture_count_ff < ppmfd_pkg::CNT_MAX) begin
                  do_store = 1'b1;
                  capture_count_in = capture_count_ff + 1'b1;
               end else begin
                  capture_count_in = '0;
                  frame_started_in = 1'b0;
               end
            end
            ppmfd_pkg::CMD_TICK: begin
               if (since_sync_ff != ppmfd_pkg::SINCE_MAX) begin
                  since_sync_in = since_sync_ff + 1'b1;
               end
            end
            ppmfd_pkg::CMD_POLL: begin
               if (since_sync_ff > cfg.loss_timeout_us) begin
                  if (!loss_latched_ff) begin
                     loss_latched_in = 1'b1;
                     published_count_in = '0;
                  end
                  warmup_count_in = '0;
               end else if (warmup_count_ff < cfg.warmup_polls) begin
                  warmup_count_in = warmup_count_ff + 1'b1;
               end else if (loss_latched_ff &&
                            published_count_ff >= ppmfd_pkg::CNT_RECOVER &&
                            published_count_ff <= ppmfd_pkg::CNT_MAX) begin
                  loss_latched_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Result fields, taken from the state after this item.
   assign readable_count = (cfg.enabled && !(warmup_count_in < cfg.warmup_polls)) ?
      published_count_in : '0;
   assign rd_ext = ppmfd_pkg::RD_W'(req.channel_index);
   assign rd_addr = rd_ext[ppmfd_pkg::IDX_W-1:0];
   assign rd_hit = (req.command == ppmfd_pkg::CMD_READ) && (rd_ext < readable_count) &&
      (rd_ext < ppmfd_pkg::RD_MAX);

   always_comb begin
      rsp.channel_value = rd_hit ? published_store_ff[rd_addr] : '0;
      rsp.channel_count = ppmfd_pkg::OUT_CNT_W'(readable_count);
      rsp.signal_lost = loss_latched_in;
      rsp.frame_done = do_publish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_started_ff <= 1'b0;
         capture_count_ff <= '0;
         published_count_ff <= '0;
         since_sync_ff <= '0;
         warmup_count_ff <= '0;
         loss_latched_ff <= 1'b0;
      end else begin
         frame_started_ff <= frame_started_in;
         capture_count_ff <= capture_count_in;
         published_count_ff <= published_count_in;
         since_sync_ff <= since_sync_in;
         warmup_count_ff <= warmup_count_in;
         loss_latched_ff <= loss_latched_in;
      end
   end

   // Channel stores: at most one capture write per item, whole copy on a sync.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ppmfd_pkg::MAX_CHANNELS; i++) begin
            capture_store_ff[i] <= '0;
            published_store_ff[i] <= '0;
         end
      end else begin
         if (do_publish) begin
            published_store_ff <= capture_store_ff;
         end
         if (do_store) begin
            capture_store_ff[store_addr] <= store_value;
         end
      end
   end

   // A capture count is only ever held inside a started frame.
   a_count_needs_frame: assert property (@(posedge clock) disable iff (reset)
      !frame_started_ff |-> capture_count_ff == '0)
      else $error("capture count held outside a frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      capture_count_ff <= ppmfd_pkg::CNT_MAX)
      else $error("capture count beyond channel limit");

   a_sync_restarts: assert property (@(posedge clock) disable iff (reset)
      do_publish |=> frame_started_ff && capture_count_ff == '0 && since_sync_ff == '0)
      else $error("sync did not restart the frame");

   a_loss_clears_count: assert property (@(posedge clock) disable iff (reset)
      $rose(loss_latched_ff) |-> published_count_ff == '0)
      else $error("loss latched with channels still published");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      fire && req.command == ppmfd_pkg::CMD_TICK && since_sync_ff != ppmfd_pkg::SINCE_MAX
      |=> since_sync_ff == $past(since_sync_ff) + 1'b1)
      else $error("tick did not advance the since-sync counter");

endmodule

### hdl/ppm_frame_decoder.sv
// Channel   Direction  Transfer when               Carries
// req_chan  in         valid && ready at clock     command, interval_us, channel_index
// rsp_chan  out        valid && ready at clock     channel_value, channel_count,
//                                                  signal_lost, frame_done
// csr_*     in/out     psel && penable && pwrite   register index paddr[4:2], pwdata
//
// One request transfer per cycle is sustained while rsp_chan.ready stays high; each
// request gives one response. A request is held in the input register and its
// response is loaded into the output register when the pipeline advances.
// All decoding is one pass of logic between those two registers.
// Reset is synchronous: it clears the decoder state and both channel stores and loads
// the register defaults. While the output register is full and rsp_chan.ready is low,
// the output register holds and the input register still takes one request.
module ppm_frame_decoder (
   input logic clock,
   input logic reset,
   ppmfd_req_if.sink req_chan,
   ppmfd_rsp_if.source rsp_chan,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [ppmfd_pkg::PADDR_W-1:0] csr_paddr,
   input logic [ppmfd_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [ppmfd_pkg::PDATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   ppmfd_pkg::cfg_type cfg;
   ppmfd_pkg::req_type req_ff;
   ppmfd_pkg::rsp_type rsp_ff;
   ppmfd_pkg::rsp_type rsp_result;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic fire;
   logic req_take;

   ppmfd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr_psel (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg (cfg)
   );

   ppmfd_core u_core (
      .clock (clock),
      .reset (reset),
      .fire (fire),
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_result)
   );

   // Pipeline moves when the output register is free or being emptied.
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.command <= ppmfd_pkg::cmd_type'(req_chan.command);
         req_ff.interval_us <= req_chan.interval_us;
         req_ff.channel_index <= req_chan.channel_index;
      end
      if (fire) begin
         rsp_ff <= rsp_result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.channel_value = rsp_ff.channel_value;
   assign rsp_chan.channel_count = rsp_ff.channel_count;
   assign rsp_chan.signal_lost = rsp_ff.signal_lost;
   assign rsp_chan.frame_done = rsp_ff.frame_done;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ppmfd_pkg::*;

   logic clock = 1'b0;
   logic reset;

   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [PDATA_W-1:0] csr_pwdata;
   logic [PDATA_W-1:0] csr_prdata;
   logic csr_pready;

   ppmfd_req_if req_bus ();
   ppmfd_rsp_if rsp_bus ();

   ppm_frame_decoder u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Register shadow and decoder state as the checker sees them.
   cfg_type cfg;
   logic open_frame;
   count_type cap_count;
   chan_type cap_chan [MAX_CHANNELS];
   count_type pub_count;
   chan_type pub_chan [MAX_CHANNELS];
   logic [SINCE_W-1:0] since_sync;
   logic [WARMUP_W-1:0] warm_count;
   logic lost_latch;

   req_type cmd_q [$];
   rsp_type decoded_q [$];
   req_type offered;
   int send_gap;
   int stall_gap;
   int error_count;
   logic burst_mode;
   logic want_hold;
   logic hold_done;
   int hold_left;

   // Computes the status word for one request and advances the decoder state.
   function automatic rsp_type decode_step(req_type item);
      rsp_type res;
      count_type readable;
      res = '0;
      case (item.command)
         CMD_EDGE: begin
            if (item.interval_us > cfg.sync_threshold_us) begin
               pub_chan = cap_chan;
               pub_count = cap_count;
               cap_count = '0;
               open_frame = 1'b1;
               since_sync = '0;
               res.frame_done = 1'b1;
            end else if (item.interval_us > cfg.min_pulse_us &&
                         item.interval_us < cfg.max_pulse_us && open_frame &&
                         cap_count < MAX_CHANNELS) begin
               cap_chan[cap_count] = (item.interval_us > CHAN_MAX) ? CHAN_MAX :
                                     item.interval_us[CHAN_W-1:0];
               cap_count = cap_count + 1'b1;
            end else begin
               cap_count = '0;
               open_frame = 1'b0;
            end
         end
         CMD_TICK: begin
            if (since_sync != SINCE_MAX) since_sync = since_sync + 1'b1;
         end
         CMD_POLL: begin
            if (since_sync > cfg.loss_timeout_us) begin
               if (!lost_latch) begin
                  lost_latch = 1'b1;
                  pub_count = '0;
               end
               warm_count = '0;
            end else if (warm_count < cfg.warmup_polls) begin
               warm_count = warm_count + 1'b1;
            end else if (lost_latch && pub_count >= MIN_RECOVER_CHANNELS &&
                         pub_count <= MAX_CHANNELS) begin
               lost_latch = 1'b0;
            end
         end
         default: ;
      endcase
      readable = (!cfg.enabled || warm_count < cfg.warmup_polls) ? '0 : pub_count;
      if (item.command == CMD_READ && item.channel_index < readable)
         res.channel_value = pub_chan[item.channel_index];
      res.channel_count = OUT_CNT_W'(readable);
      res.signal_lost = lost_latch;
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int next_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(99, 0);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      if (r < 99) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // An interval that the current settings take as a sync, or any interval when none can be.
   function automatic int pick_sync();
      if (cfg.sync_threshold_us == '1) return $urandom_range(65535, 0);
      return $urandom_range(65535, int'(cfg.sync_threshold_us) + 1);
   endfunction

   // An interval inside the pulse window that is not also a sync; any interval when the window is empty.
   function automatic int pick_channel();
      int lo;
      int hi;
      lo = int'(cfg.min_pulse_us) + 1;
      hi = int'(cfg.max_pulse_us) - 1;
      if (hi > int'(cfg.sync_threshold_us)) hi = int'(cfg.sync_threshold_us);
      if (lo <= hi) return $urandom_range(hi, lo);
      return $urandom_range(65535, 0);
   endfunction

   task automatic push_item(cmd_type c, int iv, int idx);
      req_type item;
      item.command = c;
      item.interval_us = iv[INTERVAL_W-1:0];
      item.channel_index = idx[CHIDX_W-1:0];
      cmd_q.push_back(item);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(reg_index_type idx, logic [PDATA_W-1:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ENABLED: cfg.enabled = val[0];
         REG_SYNC_THRESHOLD: cfg.sync_threshold_us = val[INTERVAL_W-1:0];
         REG_MIN_PULSE: cfg.min_pulse_us = val[INTERVAL_W-1:0];
         REG_MAX_PULSE: cfg.max_pulse_us = val[INTERVAL_W-1:0];
         REG_LOSS_TIMEOUT: cfg.loss_timeout_us = val[SINCE_W-1:0];
         REG_WARMUP_POLLS: cfg.warmup_polls = val[WARMUP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int en, int thr, int mn, int mx, int loss, int warm);
      csr_write(REG_ENABLED, en);
      csr_write(REG_SYNC_THRESHOLD, thr);
      csr_write(REG_MIN_PULSE, mn);
      csr_write(REG_MAX_PULSE, mx);
      csr_write(REG_LOSS_TIMEOUT, loss);
      csr_write(REG_WARMUP_POLLS, warm);
   endtask

   // Waits until every request went through and every status word came back.
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_q.size() != 0 || req_bus.valid || decoded_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Mostly well-formed frames with random content, mixed with ticks, polls,
   // reads and some noise.
   task automatic random_phase(int n);
      int start;
      int r;
      int k;
      start = cmd_q.size();
      while (cmd_q.size() - start < n) begin
         r = $urandom_range(99, 0);
         if (r < 45) begin
            push_item(CMD_EDGE, pick_sync(), 0);
            k = $urandom_range(18, 0);
            repeat (k) begin
               if ($urandom_range(19, 0) == 0)
                  push_item(CMD_EDGE, $urandom_range(65535, 0), 0);
               else
                  push_item(CMD_EDGE, pick_channel(), 0);
            end
         end else if (r < 60) begin
            repeat ($urandom_range(30, 1)) push_item(CMD_TICK, 0, 0);
         end else if (r < 75) begin
            repeat ($urandom_range(5, 1)) push_item(CMD_POLL, 0, 0);
         end else if (r < 92) begin
            repeat ($urandom_range(4, 1))
               push_item(CMD_READ, $urandom_range(65535, 0), $urandom_range(15, 0));
         end else begin
            push_item(cmd_type'($urandom_range(3, 0)), $urandom_range(65535, 0),
                      $urandom_range(15, 0));
         end
      end
   endtask

   // Request driver: holds an offer until it is taken, predicts on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) decoded_q.push_back(decode_step(offered));
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
               offered = cmd_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.command <= offered.command;
               req_bus.interval_us <= offered.interval_us;
               req_bus.channel_index <= offered.channel_index;
               send_gap = next_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, requested once by the stimulus.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (want_hold && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each transfer against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decoded_q.size() == 0) begin
               $error("status word arrived with no request outstanding");
               error_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_bus.channel_value !== want.channel_value) begin
                  $error("channel_value expected %0d got %0d", want.channel_value,
                         rsp_bus.channel_value);
                  error_count++;
               end
               if (rsp_bus.channel_count !== want.channel_count) begin
                  $error("channel_count expected %0d got %0d", want.channel_count,
                         rsp_bus.channel_count);
                  error_count++;
               end
               if (rsp_bus.signal_lost !== want.signal_lost) begin
                  $error("signal_lost expected %0d got %0d", want.signal_lost,
                         rsp_bus.signal_lost);
                  error_count++;
               end
               if (rsp_bus.frame_done !== want.frame_done) begin
                  $error("frame_done expected %0d got %0d", want.frame_done,
                         rsp_bus.frame_done);
                  error_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_gap = next_gap();
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_EDGE;
      req_bus.interval_us = '0;
      req_bus.channel_index = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      burst_mode = 1'b0;
      want_hold = 1'b0;
      cfg.enabled = 1'b0;
      cfg.sync_threshold_us = RST_SYNC_THRESHOLD;
      cfg.min_pulse_us = RST_MIN_PULSE;
      cfg.max_pulse_us = RST_MAX_PULSE;
      cfg.loss_timeout_us = RST_LOSS_TIMEOUT;
      cfg.warmup_polls = RST_WARMUP_POLLS;
      open_frame = 1'b0;
      cap_count = '0;
      pub_count = '0;
      since_sync = '0;
      warm_count = '0;
      lost_latch = 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         cap_chan[i] = '0;
         pub_chan[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Decoder still disabled after reset.
      push_item(CMD_READ, 0, 0);
      push_item(CMD_TICK, 0, 0);
      push_item(CMD_POLL, 0, 0);
      push_item(CMD_EDGE, 65535, 0);
      wait_drained();

      // Directed: window edges, publish, warm-up, reads in and out of range, loss.
      set_config(1, 2990, 900, 2100, 3, 2);
      push_item(CMD_EDGE, 2991, 0);
      push_item(CMD_EDGE, 901, 0);
      push_item(CMD_EDGE, 2099, 0);
      push_item(CMD_EDGE, 1500, 0);
      push_item(CMD_EDGE, 1234, 0);
      push_item(CMD_EDGE, 65535, 0);
      push_item(CMD_READ, 0, 0);
      push_item(CMD_POLL, 0, 0);
      push_item(CMD_POLL, 0, 0);
      push_item(CMD_READ, 0, 0);
      push_item(CMD_READ, 0, 3);
      push_item(CMD_READ, 0, 4);
      push_item(CMD_READ, 65535, 15);
      push_item(CMD_EDGE, 900, 0);
      push_item(CMD_EDGE, 2100, 0);
      push_item(CMD_EDGE, 2990, 0);
      push_item(CMD_EDGE, 0, 0);
      repeat (4) push_item(CMD_TICK, 0, 0);
      push_item(CMD_POLL, 0, 0);
      push_item(CMD_READ, 0, 0);
      push_item(CMD_POLL, 0, 0);
      wait_drained();

      // Nominal timing with a short loss timeout; the receiver stalls long here.
      set_config(1, 2990, 900, 2100, 25, 3);
      random_phase(350);
      want_hold = 1'b1;
      wait_drained();

      // Wide pulse window, so stored values saturate; loss can never trigger.
      set_config(1, 5000, 0, 65535, 131071, 31);
      random_phase(200);
      wait_drained();

      // Disabled decoder, run back to back without idling.
      burst_mode = 1'b1;
      set_config(0, 2990, 900, 2100, 25, 3);
      random_phase(100);
      wait_drained();
      burst_mode = 1'b0;

      // Every nonzero interval is a sync and the pulse window is empty.
      set_config(1, 0, 65535, 0, 0, 0);
      random_phase(150);
      wait_drained();

      // Nothing can be a sync.
      set_config(1, 65535, 0, 65535, 40, 1);
      random_phase(100);
      wait_drained();

      set_config(1, 3000, 800, 2200, 12, 5);
      random_phase(250);
      wait_drained();

      // Since-sync counter runs past the timeout, then loss and recovery.
      burst_mode = 1'b1;
      set_config(1, 2990, 900, 2100, 10, 2);
      push_item(CMD_EDGE, 3000, 0);
      repeat (15) push_item(CMD_TICK, 0, 0);
      push_item(CMD_POLL, 0, 0);
      push_item(CMD_READ, 0, 0);
      push_item(CMD_EDGE, 3000, 0);
      repeat (5) push_item(CMD_EDGE, 1500, 0);
      push_item(CMD_EDGE, 3000, 0);
      repeat (4) push_item(CMD_POLL, 0, 0);
      push_item(CMD_READ, 0, 4);
      wait_drained();

      repeat (10) @(posedge clock);
      if (error_count == 0 && decoded_q.size() == 0) begin
         $display("[ppm_frame_decoder] OK");
      end else begin
         $display("[ppm_frame_decoder] ERROR");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("[ppm_frame_decoder] ERROR");
      $finish;
   end

endmodule

### filelist.f
hdl/ppmfd_pkg.sv
hdl/ppmfd_req_if.sv
hdl/ppmfd_rsp_if.sv
hdl/ppmfd_csr.sv
hdl/ppmfd_core.sv
hdl/ppm_frame_decoder.sv
verif/tb_top.sv
